FILE: design/sorted_descending_priority_queue_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted descending priority queue
// Clocked property helpers with active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef SORTED_DESCENDING_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_DESCENDING_PRIORITY_QUEUE_TOP_ASSERT_SVH

// same-cycle implication
`define SDPQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sdpq assertion failed");

// next-cycle implication
`define SDPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sdpq assertion failed");

`endif

FILE: design/sdpq_pkg.sv
// ----------------------------------------------------------------------------
// sdpq_pkg
// Shared types and codes for the sorted descending priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package sdpq_pkg;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  // command broadcast to every cell
  typedef struct packed {
    logic enq;
    logic deq;
  } cmd_t;

endpackage

`default_nettype wire

FILE: design/sdpq_cell.sv
// ----------------------------------------------------------------------------
// sdpq_cell
// One slot of the sorted chain: holds a value, shifts right on insert,
// shifts left on removal.
// ----------------------------------------------------------------------------
`default_nettype none

module sdpq_cell
  import sdpq_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  wire                          clk,
  input  wire  cmd_t                   cmd,
  input  wire                          occ,
  input  wire  logic signed [VALUE_BITS-1:0] new_value,
  input  wire                          left_ge,
  input  wire  logic signed [VALUE_BITS-1:0] left_entry,
  input  wire  logic signed [VALUE_BITS-1:0] right_entry,
  output logic signed [VALUE_BITS-1:0] entry,
  output logic                         ge
);

  logic signed [VALUE_BITS-1:0] entry_r;
  logic signed [VALUE_BITS-1:0] entry_nxt;

  // stored value stays ahead of an equal newcomer
  assign ge    = occ && !(new_value > entry_r);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.deq) begin
      entry_nxt = right_entry;
    end else if (cmd.enq && !ge) begin
      entry_nxt = left_ge ? new_value : left_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

FILE: design/sorted_descending_priority_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_descending_priority_queue_top
// Sorted priority queue built from a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// One word is accepted per clock. Every cell compares the incoming value
// against its own entry in parallel, so the time an insert or a removal
// takes does not depend on the fill level; the result word is registered and
// appears the cycle after acceptance. in_ready only drops while a result is
// held back by out_ready, so the output register sets the rate at one word
// per cycle when the consumer keeps up.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_descending_priority_queue_top
  import sdpq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int VALUE_BITS = 32
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire                                   in_action,
  input  wire  logic signed [VALUE_BITS-1:0]    in_value,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic [1:0]                            out_status,
  output logic signed [VALUE_BITS-1:0]          out_removed_value,
  output logic [$clog2(DEPTH+1)-1:0]            out_entry_count,
  output logic                                  out_is_empty,
  output logic                                  out_is_full
);

  localparam int CW = $clog2(DEPTH + 1);

  logic                         accept;
  logic                         full;
  logic                         empty;
  cmd_t                         cmd;
  logic [CW-1:0]                count_r, count_nxt;
  logic                         out_valid_r, out_valid_nxt;
  status_t                      status_r, status_nxt;
  logic signed [VALUE_BITS-1:0] removed_r, removed_nxt;
  logic [CW-1:0]                cnt_out_r;
  logic                         empty_r, full_r;

  logic signed [VALUE_BITS-1:0] entry_w [DEPTH];
  logic                         ge_w    [DEPTH];

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);

  always_comb begin
    cmd         = '0;
    count_nxt   = count_r;
    status_nxt  = ST_OK;
    removed_nxt = '0;
    if (accept) begin
      if (in_action == ACT_ENQ) begin
        if (full) begin
          status_nxt = ST_OVERFLOW;
        end else begin
          cmd.enq   = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end else begin
        if (empty) begin
          status_nxt = ST_UNDERFLOW;
        end else begin
          cmd.deq     = 1'b1;
          removed_nxt = entry_w[0];
          count_nxt   = count_r - CW'(1);
        end
      end
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic                         left_ge;
      logic signed [VALUE_BITS-1:0] left_entry;
      logic signed [VALUE_BITS-1:0] right_entry;

      if (gi == 0) begin : g_head
        assign left_ge    = 1'b0;
        assign left_entry = in_value;
      end else begin : g_body
        assign left_ge    = ge_w[gi-1];
        assign left_entry = entry_w[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_tail
        assign right_entry = entry_w[gi];
      end else begin : g_mid
        assign right_entry = entry_w[gi+1];
      end

      sdpq_cell #(
        .VALUE_BITS (VALUE_BITS)
      ) u_cell (
        .clk         (clk),
        .cmd         (cmd),
        .occ         (CW'(gi) < count_r),
        .new_value   (in_value),
        .left_ge     (left_ge),
        .left_entry  (left_entry),
        .right_entry (right_entry),
        .entry       (entry_w[gi]),
        .ge          (ge_w[gi])
      );
    end
  endgenerate

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status_nxt;
      removed_r <= removed_nxt;
      cnt_out_r <= count_nxt;
      empty_r   <= (count_nxt == '0);
      full_r    <= (count_nxt == CW'(DEPTH));
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_removed_value = removed_r;
  assign out_entry_count   = cnt_out_r;
  assign out_is_empty      = empty_r;
  assign out_is_full       = full_r;

`include "sorted_descending_priority_queue_top_assert.svh"

  `SDPQ_ASSERT_SAME(a_count_max, clk, rst_n, 1'b1, count_r <= CW'(DEPTH))
  `SDPQ_ASSERT_NEXT(a_stall_holds_count, clk, rst_n, out_valid_r && !out_ready, $stable(count_r))
  `SDPQ_ASSERT_NEXT(a_enq_grows, clk, rst_n, cmd.enq, count_r == $past(count_r) + CW'(1))
  `SDPQ_ASSERT_SAME(a_head_sorted, clk, rst_n, count_r >= CW'(2), entry_w[0] >= entry_w[1])

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted descending priority queue. Words are
// pushed through the valid/ready input with random gaps while the result side
// stalls at random. Each accepted word updates a local sorted list that
// predicts the result word, which is compared field by field on acceptance.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
  import sdpq_pkg::*;
();

  localparam int DEPTH      = 16;
  localparam int VALUE_BITS = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    status_t                      status;
    logic signed [VALUE_BITS-1:0] removed;
    logic [CNT_W-1:0]             count;
    logic                         empty;
    logic                         full;
  } pq_result_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic                         in_action;
  logic signed [VALUE_BITS-1:0] in_value;
  logic                         out_valid;
  logic                         out_ready;
  logic [1:0]                   out_status;
  logic signed [VALUE_BITS-1:0] out_removed_value;
  logic [CNT_W-1:0]             out_entry_count;
  logic                         out_is_empty;
  logic                         out_is_full;

  // predicted contents, largest first
  logic signed [VALUE_BITS-1:0] held_vals[$];
  pq_result_t                   pending_results[$];
  int unsigned                  n_fail;
  int unsigned                  quiet_cycles;
  bit                           tx_idle_on;
  bit                           rx_idle_on;
  int unsigned                  rx_hold_req;

  sorted_descending_priority_queue_top #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_removed_value (out_removed_value),
    .out_entry_count   (out_entry_count),
    .out_is_empty      (out_is_empty),
    .out_is_full       (out_is_full)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] pick_value();
    logic signed [VALUE_BITS-1:0] v;
    int unsigned                  r;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      // narrow range so that ties are common
      v = $urandom_range(0, 8);
      v = v - 4;
    end else if (r < 45) begin
      case ($urandom_range(0, 3))
        0:       v = 32'sh7fff_ffff;
        1:       v = 32'sh8000_0000;
        2:       v = 32'sh7fff_fffe;
        default: v = 32'sh8000_0001;
      endcase
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  function automatic pq_result_t predict_outcome(input logic act,
                                                 input logic signed [VALUE_BITS-1:0] val);
    pq_result_t r;
    int         pos;
    r.status  = ST_OK;
    r.removed = '0;
    if (act == ACT_ENQ) begin
      if (held_vals.size() >= DEPTH) begin
        r.status = ST_OVERFLOW;
      end else begin
        // behind every stored value that is greater or equal
        pos = 0;
        while (pos < held_vals.size() && held_vals[pos] >= val) pos++;
        held_vals.insert(pos, val);
      end
    end else if (held_vals.size() == 0) begin
      r.status = ST_UNDERFLOW;
    end else begin
      r.removed = held_vals.pop_front();
    end
    r.count = CNT_W'(held_vals.size());
    r.empty = (held_vals.size() == 0);
    r.full  = (held_vals.size() == DEPTH);
    return r;
  endfunction

  task automatic send_word(input logic act, input logic signed [VALUE_BITS-1:0] val);
    int unsigned gap;
    gap = tx_idle_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    in_action = act;
    in_value  = val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_outcome(act, val));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls, or a long hold-off on request
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (rx_hold_req != 0) begin
        out_ready = 1'b0;
        repeat (rx_hold_req - 1) @(negedge clk);
        rx_hold_req = 0;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat (pick_gap()) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    pq_result_t exp;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        n_fail++;
      end else begin
        exp = pending_results.pop_front();
        if (out_status !== exp.status) begin
          $error("status: expected %0d, got %0d", exp.status, out_status);
          n_fail++;
        end
        if (out_removed_value !== exp.removed) begin
          $error("removed_value: expected %0d, got %0d", exp.removed, out_removed_value);
          n_fail++;
        end
        if (out_entry_count !== exp.count) begin
          $error("entry_count: expected %0d, got %0d", exp.count, out_entry_count);
          n_fail++;
        end
        if (out_is_empty !== exp.empty) begin
          $error("is_empty: expected %0b, got %0b", exp.empty, out_is_empty);
          n_fail++;
        end
        if (out_is_full !== exp.full) begin
          $error("is_full: expected %0b, got %0b", exp.full, out_is_full);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // empty dequeue, fill with extremes and ties, full enqueue, a few removals
  task automatic test_directed_corners();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_word(ACT_DEQ, 32'sh5a5a_a5a5);
    send_word(ACT_ENQ, 32'sh0000_0000);
    send_word(ACT_ENQ, 32'sh7fff_ffff);
    send_word(ACT_ENQ, 32'sh8000_0000);
    send_word(ACT_ENQ, -32'sd1);
    send_word(ACT_ENQ, 32'sd1);
    send_word(ACT_ENQ, 32'sd1);
    send_word(ACT_ENQ, 32'sh7fff_ffff);
    send_word(ACT_ENQ, 32'sh8000_0000);
    send_word(ACT_ENQ, 32'sh0000_0000);
    send_word(ACT_ENQ, 32'sh5555_5555);
    send_word(ACT_ENQ, 32'shaaaa_aaaa);
    send_word(ACT_ENQ, 32'sh7fff_fffe);
    send_word(ACT_ENQ, 32'sh8000_0001);
    send_word(ACT_ENQ, -32'sd1);
    send_word(ACT_ENQ, 32'sd1);
    send_word(ACT_ENQ, 32'sh1234_5678);
    send_word(ACT_ENQ, 32'sh7fff_ffff);
    send_word(ACT_DEQ, 32'shffff_ffff);
    send_word(ACT_DEQ, 32'sh0000_0000);
    send_word(ACT_ENQ, 32'sh7fff_ffff);
    send_word(ACT_DEQ, 32'sh0000_0000);
  endtask

  // long receiver hold-off while the sender keeps offering words
  task automatic test_backpressure_fill();
    tx_idle_on  = 1'b0;
    rx_idle_on  = 1'b0;
    rx_hold_req = 150;
    repeat (40) send_word(($urandom_range(0, 3) == 0) ? ACT_DEQ : ACT_ENQ, pick_value());
  endtask

  // sender stops until every result is back, then carries on
  task automatic test_drain_pause();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (15) send_word(($urandom_range(0, 2) == 0) ? ACT_DEQ : ACT_ENQ, pick_value());
    wait_drained();
    repeat (15) send_word(($urandom_range(0, 2) == 0) ? ACT_ENQ : ACT_DEQ, pick_value());
    wait_drained();
  endtask

  // bursts leaning towards filling or emptying, so full and empty recur
  task automatic test_random_traffic(input int unsigned n_words);
    int unsigned enq_pct;
    int unsigned burst;
    int unsigned sent;
    sent = 0;
    while (sent < n_words) begin
      case ($urandom_range(0, 3))
        0:       enq_pct = 85;
        1:       enq_pct = 15;
        default: enq_pct = 50;
      endcase
      burst = $urandom_range(8, 40);
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      repeat (burst) begin
        send_word(($urandom_range(0, 99) < enq_pct) ? ACT_ENQ : ACT_DEQ, pick_value());
        sent++;
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_action    = ACT_ENQ;
    in_value     = '0;
    n_fail       = 0;
    quiet_cycles = 0;
    tx_idle_on   = 1'b0;
    rx_idle_on   = 1'b0;
    rx_hold_req  = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_corners();
    test_backpressure_fill();
    test_drain_pause();
    test_random_traffic(760);

    wait_drained();
    repeat (8) @(posedge clk);
    if (n_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sorted_descending_priority_queue_top.f
+incdir+design
design/sdpq_pkg.sv
design/sdpq_cell.sv
design/sorted_descending_priority_queue_top.sv
tb/tb_top.sv
